@@ rtl/met_pkg.sv @@
package met_pkg;

    // coordinate format: signed, FX_FRAC fraction bits (Q4.28)
    localparam int FX_FRAC = 28;
    // width of c and of the unbounded z registers
    localparam int C_W = 48;
    // multiplier operand width, enough for |z| < 2
    localparam int Z_W = FX_FRAC + 3;
    localparam int P_W = 2 * Z_W;

    localparam logic signed [C_W-1:0] TWO_FX  = C_W'(1) <<< (FX_FRAC + 1);
    localparam logic signed [C_W-1:0] FOUR_FX = C_W'(1) <<< (FX_FRAC + 2);

    localparam int COL_W    = 12;
    localparam int ROW_W    = 12;
    localparam int ITER_W   = 16;
    localparam int COLOUR_W = 24;
    localparam logic [COLOUR_W-1:0] COLOUR_MAX = '1;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register index, byte address is 4*index
    typedef enum logic [2:0] {
        REG_RE_ORIGIN   = 3'd0,
        REG_REAL_STEP   = 3'd1,
        REG_IM_ORIGIN   = 3'd2,
        REG_IMAG_STEP   = 3'd3,
        REG_HEIGHT      = 3'd4,
        REG_MAX_ITER    = 3'd5,
        REG_COLOUR_BASE = 3'd6,
        REG_COLOUR_STEP = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] re_origin;
        logic [30:0] real_step;
        logic [31:0] im_origin;
        logic [30:0] imag_step;
        logic [12:0] image_height;
        logic [15:0] max_iter;
        logic [23:0] colour_base;
        logic [31:0] colour_step;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic calc_c;
        logic init_z;
        logic mul;
        logic step;
        logic calc_col;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic big;
        logic esc_sq;
        logic count_max;
    } t_sts;

endpackage

@@ rtl/met_regs.sv @@
module met_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [met_pkg::APB_AW-1:0]    paddr,
    input  logic [met_pkg::APB_DW-1:0]    pwdata,
    output logic [met_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output met_pkg::t_cfg                 o_cfg
);
    import met_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.re_origin    <= 32'hE000_0000;
            r_cfg.real_step    <= 31'd1073742;
            r_cfg.im_origin    <= 32'hE000_0000;
            r_cfg.imag_step    <= 31'd1073742;
            r_cfg.image_height <= 13'd1000;
            r_cfg.max_iter     <= 16'd10000;
            r_cfg.colour_base  <= 24'd0;
            r_cfg.colour_step  <= 32'd65536;
        end else if (w_wr) begin
            case (w_idx)
                REG_RE_ORIGIN:   r_cfg.re_origin    <= pwdata;
                REG_REAL_STEP:   r_cfg.real_step    <= pwdata[30:0];
                REG_IM_ORIGIN:   r_cfg.im_origin    <= pwdata;
                REG_IMAG_STEP:   r_cfg.imag_step    <= pwdata[30:0];
                REG_HEIGHT:      r_cfg.image_height <= pwdata[12:0];
                REG_MAX_ITER:    r_cfg.max_iter     <= pwdata[15:0];
                REG_COLOUR_BASE: r_cfg.colour_base  <= pwdata[23:0];
                REG_COLOUR_STEP: r_cfg.colour_step  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RE_ORIGIN:   prdata = r_cfg.re_origin;
            REG_REAL_STEP:   prdata = {1'b0, r_cfg.real_step};
            REG_IM_ORIGIN:   prdata = r_cfg.im_origin;
            REG_IMAG_STEP:   prdata = {1'b0, r_cfg.imag_step};
            REG_HEIGHT:      prdata = {19'd0, r_cfg.image_height};
            REG_MAX_ITER:    prdata = {16'd0, r_cfg.max_iter};
            REG_COLOUR_BASE: prdata = {8'd0, r_cfg.colour_base};
            REG_COLOUR_STEP: prdata = r_cfg.colour_step;
            default:         prdata = '0;
        endcase
    end

endmodule

@@ rtl/met_dp.sv @@
module met_dp (
    input  logic                           i_clk,
    input  met_pkg::t_cfg                  i_cfg,
    input  met_pkg::t_cmd                  i_cmd,
    input  logic [met_pkg::COL_W-1:0]      i_col,
    input  logic [met_pkg::ROW_W-1:0]      i_row,
    output met_pkg::t_sts                  o_sts,
    output logic [met_pkg::COLOUR_W-1:0]   o_colour,
    output logic [met_pkg::ITER_W-1:0]     o_iter
);
    import met_pkg::*;

    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic [42:0]             r_prod_re;
    logic signed [46:0]      r_prod_im;
    logic signed [C_W-1:0]   r_cr, r_ci, r_zr, r_zi;
    logic [ITER_W-1:0]       r_count;
    logic signed [P_W-1:0]   r_p_rr, r_p_ii, r_p_ri;
    logic [47:0]             r_col_prod;
    logic [COLOUR_W-1:0]     r_out_colour;
    logic [ITER_W-1:0]       r_out_iter;

    logic signed [14:0]      w_flip;
    logic [42:0]             n_prod_re;
    logic signed [46:0]      n_prod_im;
    logic signed [C_W-1:0]   n_cr, n_ci;
    logic signed [Z_W-1:0]   w_zr_s, w_zi_s;
    logic signed [P_W-1:0]   w_sh_rr, w_sh_ii, w_sh_ri;
    logic signed [C_W-1:0]   w_sq_r, w_sq_i, w_x2, w_sum_sq;
    logic signed [C_W-1:0]   n_zr, n_zi;
    logic [ITER_W-1:0]       w_cnt_m1;
    logic [32:0]             w_colour_sum;
    logic [COLOUR_W-1:0]     n_out_colour;

    // c mapping, row flipped so the top row is the largest imaginary part
    assign w_flip    = $signed({2'b00, i_cfg.image_height}) - 15'sd1
                     - $signed({3'b000, r_row});
    assign n_prod_re = 43'(r_col) * 43'(i_cfg.real_step);
    assign n_prod_im = 47'(w_flip) * 47'($signed({1'b0, i_cfg.imag_step}));
    assign n_cr      = {{(C_W-32){i_cfg.re_origin[31]}}, i_cfg.re_origin}
                     + $signed({{(C_W-43){1'b0}}, r_prod_re});
    assign n_ci      = {{(C_W-32){i_cfg.im_origin[31]}}, i_cfg.im_origin}
                     + C_W'(r_prod_im);

    // operands are only meaningful while |z| < 2
    assign w_zr_s = r_zr[Z_W-1:0];
    assign w_zi_s = r_zi[Z_W-1:0];

    // arithmetic shift of the exact product is the floor
    assign w_sh_rr  = r_p_rr >>> FX_FRAC;
    assign w_sh_ii  = r_p_ii >>> FX_FRAC;
    assign w_sh_ri  = r_p_ri >>> (FX_FRAC - 1);
    assign w_sq_r   = w_sh_rr[C_W-1:0];
    assign w_sq_i   = w_sh_ii[C_W-1:0];
    assign w_x2     = w_sh_ri[C_W-1:0];
    assign w_sum_sq = w_sq_r + w_sq_i;
    assign n_zr     = w_sq_r - w_sq_i + r_cr;
    assign n_zi     = w_x2 + r_ci;

    assign o_sts.big       = (r_zr >= TWO_FX) || (r_zr <= -TWO_FX)
                          || (r_zi >= TWO_FX) || (r_zi <= -TWO_FX);
    assign o_sts.esc_sq    = w_sum_sq >= FOUR_FX;
    assign o_sts.count_max = r_count >= i_cfg.max_iter;

    // colour = base + floor((count-1)*step / 2^16), saturated
    assign w_cnt_m1     = r_count - ITER_W'(1);
    assign w_colour_sum = 33'(i_cfg.colour_base) + 33'(r_col_prod[47:16]);
    assign n_out_colour = (w_colour_sum > 33'(COLOUR_MAX)) ? COLOUR_MAX
                                                          : w_colour_sum[COLOUR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= i_col;
            r_row <= i_row;
        end
        if (i_cmd.calc_c) begin
            r_prod_re <= n_prod_re;
            r_prod_im <= n_prod_im;
        end
        if (i_cmd.init_z) begin
            r_cr    <= n_cr;
            r_ci    <= n_ci;
            r_zr    <= n_cr;
            r_zi    <= n_ci;
            r_count <= ITER_W'(1);
        end
        if (i_cmd.mul) begin
            r_p_rr <= P_W'(w_zr_s) * P_W'(w_zr_s);
            r_p_ii <= P_W'(w_zi_s) * P_W'(w_zi_s);
            r_p_ri <= P_W'(w_zr_s) * P_W'(w_zi_s);
        end
        if (i_cmd.step) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_count <= r_count + ITER_W'(1);
        end
        if (i_cmd.calc_col) begin
            r_col_prod <= 48'(w_cnt_m1) * 48'(i_cfg.colour_step);
        end
        if (i_cmd.load_out) begin
            r_out_colour <= n_out_colour;
            r_out_iter   <= r_count;
        end
    end

    assign o_colour = r_out_colour;
    assign o_iter   = r_out_iter;

endmodule

@@ rtl/met_ctrl.sv @@
module met_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  met_pkg::t_sts  i_sts,
    output met_pkg::t_cmd  o_cmd
);
    import met_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CADD,
        ST_MUL,
        ST_STEP,
        ST_COL,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_CMUL;
                end
            end
            ST_CMUL: begin
                o_cmd.calc_c = 1'b1;
                n_state      = ST_CADD;
            end
            ST_CADD: begin
                o_cmd.init_z = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_sts.big || i_sts.count_max) begin
                    n_state = ST_COL;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (i_sts.esc_sq) begin
                    n_state = ST_COL;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_COL: begin
                o_cmd.calc_col = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/mandelbrot_escape_time_pixel_unit.sv @@
// channel   | dir | signals                     | contents
// ----------+-----+-----------------------------+-----------------------------------
// s_axis    | in  | tvalid tready tdata[23:0]   | pixel_col, pixel_row
// m_axis    | out | tvalid tready tdata[39:0]   | pixel_colour, iterations
// apb       | in  | psel penable pwrite paddr   | eight 32-bit config registers
//
// a pixel occupies the unit from accept to the next ready through the mapping,
// escape loop, colour and output states: the escape loop runs one registered
// multiply and one add/test step per iteration
// one pixel is in flight at a time; the next request is taken once the result
// is parked in the output register, even if the sink has not taken it yet
// reset (synchronous, active low) restores default registers and empties the output
// a stalled sink holds the unit only when a second result is ready to leave
module mandelbrot_escape_time_pixel_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel requests
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,   // pixel_col[11:0], pixel_row[23:12]
    // results
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [39:0]                 m_axis_tdata,   // pixel_colour[23:0], iterations[39:24]
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [met_pkg::APB_AW-1:0]  paddr,
    input  logic [met_pkg::APB_DW-1:0]  pwdata,
    output logic [met_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import met_pkg::*;

    t_cfg                w_cfg;
    t_cmd                w_cmd;
    t_sts                w_sts;
    logic [COLOUR_W-1:0] w_colour;
    logic [ITER_W-1:0]   w_iter;

    // register bank, to be written only while the unit is idle; the bank itself does not enforce it
    met_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: map, iterate, colour, hand off
    met_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // fixed-point c mapping, z update, escape tests and colour scale
    met_dp u_dp (
        .i_clk    (i_clk),
        .i_cfg    (w_cfg),
        .i_cmd    (w_cmd),
        .i_col    (s_axis_tdata[COL_W-1:0]),
        .i_row    (s_axis_tdata[COL_W+ROW_W-1:COL_W]),
        .o_sts    (w_sts),
        .o_colour (w_colour),
        .o_iter   (w_iter)
    );

    assign m_axis_tdata = {w_iter, w_colour};

endmodule

@@ rtl/met_port_checker.sv @@
module met_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // at least one iteration is always reported
    a_iter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:24] != 16'd0)
        else $error("zero iteration count");

    // one pixel at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // a fresh result needs at least the mapping and one iteration
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 !m_axis_tvalid)
        else $error("result too soon after request");

endmodule

bind mandelbrot_escape_time_pixel_unit met_port_checker u_port_checker (.*);

@@ sim/mandelbrot_escape_time_pixel_unit_test.sv @@
module mandelbrot_escape_time_pixel_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import met_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    // long sink hold-off, far longer than a few short-iteration requests take
    localparam int LONG_STALL   = 300;
    // quiet cycles after the last result before config writes or the verdict
    localparam int SETTLE       = 8;

    // laid out like m_axis_tdata: colour in the low bits, count above
    typedef struct packed {
        logic [ITER_W-1:0]   iterations;
        logic [COLOUR_W-1:0] colour;
    } t_pixel_out;

    localparam t_cfg RESET_CFG = '{
        re_origin:    32'hE000_0000,
        real_step:    31'd1073742,
        im_origin:    32'hE000_0000,
        imag_step:    31'd1073742,
        image_height: 13'd1000,
        max_iter:     16'd10000,
        colour_base:  24'd0,
        colour_step:  32'h0001_0000
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata;   // pixel_col[11:0], pixel_row[23:12]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [39:0]         m_axis_tdata;   // pixel_colour[23:0], iterations[39:24]
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // shadow of the register file, kept in step with every apb write
    t_cfg       cfg_shadow;
    // expected results of accepted requests, oldest first
    t_pixel_out awaited_pixels[$];
    int         mismatch_count;
    // random idle bursts on the request side and on the result side
    bit         src_idle_en;
    bit         sink_idle_en;
    // set by a test to make the sink hold off for that many cycles
    int         sink_stall_req;

    mandelbrot_escape_time_pixel_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // floor(a*b / 2^shift) from the exact signed double-width product
    function automatic longint fx_floor_mul(longint a, longint b, int shift);
        logic signed [127:0] prod;
        prod = 128'(a);
        prod = prod * 128'(b);
        return longint'(prod >>> shift);
    endfunction

    // escape-time count and colour of one pixel under the shadow registers
    function automatic t_pixel_out escape_time(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        longint          two;
        longint          four;
        longint          flip;
        longint          c_re;
        longint          c_im;
        longint          z_re;
        longint          z_im;
        longint          next_re;
        longint unsigned count;
        longint unsigned shade;
        bit              escaped;
        t_pixel_out      res;
        two  = longint'(1) <<< (FX_FRAC + 1);
        four = longint'(1) <<< (FX_FRAC + 2);
        // row zero is the top, so flip it; rows at or past the height go negative
        flip = longint'(cfg_shadow.image_height) - 1 - longint'(row);
        // c is kept exact, never clipped to the coordinate format
        c_re = longint'($signed(cfg_shadow.re_origin))
             + longint'(col) * longint'(cfg_shadow.real_step);
        c_im = longint'($signed(cfg_shadow.im_origin))
             + flip * longint'(cfg_shadow.imag_step);
        z_re  = 0;
        z_im  = 0;
        count = 0;
        // at least one step is always taken, even with a zero limit
        do begin
            next_re = fx_floor_mul(z_re, z_re, FX_FRAC) - fx_floor_mul(z_im, z_im, FX_FRAC)
                    + c_re;
            z_im    = fx_floor_mul(z_re, z_im, FX_FRAC - 1) + c_im;
            z_re    = next_re;
            count++;
            // a coordinate at or past two already means |z|^2 >= 4
            if (z_re >= two || z_re <= -two || z_im >= two || z_im <= -two)
                escaped = 1'b1;
            else
                escaped = (fx_floor_mul(z_re, z_re, FX_FRAC)
                         + fx_floor_mul(z_im, z_im, FX_FRAC)) >= four;
        end while (!escaped && count < cfg_shadow.max_iter);
        // colour step is q16.16, result clipped to 24 bits
        shade = cfg_shadow.colour_base + (((count - 1) * cfg_shadow.colour_step) >> 16);
        res.colour     = (shade > 64'hFF_FFFF) ? COLOUR_MAX : shade[COLOUR_W-1:0];
        res.iterations = count[ITER_W-1:0];
        return res;
    endfunction

    // apb write: setup phase, access phase, then psel drops back to idle
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_RE_ORIGIN:   cfg_shadow.re_origin    = value;
            REG_REAL_STEP:   cfg_shadow.real_step    = value[30:0];
            REG_IM_ORIGIN:   cfg_shadow.im_origin    = value;
            REG_IMAG_STEP:   cfg_shadow.imag_step    = value[30:0];
            REG_HEIGHT:      cfg_shadow.image_height = value[12:0];
            REG_MAX_ITER:    cfg_shadow.max_iter     = value[15:0];
            REG_COLOUR_BASE: cfg_shadow.colour_base  = value[23:0];
            REG_COLOUR_STEP: cfg_shadow.colour_step  = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // all eight registers; bits above each field carry junk the block must drop
    task automatic write_config(t_cfg c);
        write_reg(REG_RE_ORIGIN,   c.re_origin);
        write_reg(REG_REAL_STEP,   {1'($urandom), c.real_step});
        write_reg(REG_IM_ORIGIN,   c.im_origin);
        write_reg(REG_IMAG_STEP,   {1'($urandom), c.imag_step});
        write_reg(REG_HEIGHT,      {19'($urandom), c.image_height});
        write_reg(REG_MAX_ITER,    {16'($urandom), c.max_iter});
        write_reg(REG_COLOUR_BASE, {8'($urandom), c.colour_base});
        write_reg(REG_COLOUR_STEP, c.colour_step);
    endtask

    // offer one pixel request and return at the edge that accepts it
    task automatic send_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        awaited_pixels.push_back(escape_time(col, row));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // window of 8 to 256 columns by 8 to 256 rows near the set, short iteration limit
    task automatic pick_window(output t_cfg w, output int cols, output int rows);
        cols           = $urandom_range(8, 256);
        rows           = $urandom_range(8, 256);
        w.re_origin    = 32'hD800_0000 + $urandom_range(0, 32'd805306368);
        w.real_step    = 31'($urandom_range(32'd268435456, 32'd805306368) / cols);
        w.im_origin    = 32'hE800_0000 + $urandom_range(0, 32'd268435456);
        w.imag_step    = 31'($urandom_range(32'd268435456, 32'd805306368) / rows);
        w.image_height = 13'($urandom_range(1, 4096));
        w.max_iter     = 16'($urandom_range(1, 300));
        w.colour_base  = 24'($urandom);
        w.colour_step  = $urandom >> $urandom_range(0, 31);
    endtask

    // mostly inside the window, now and then any position at all
    task automatic send_window_pixel(int cols, int rows);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        if ($urandom_range(0, 5) == 0) begin
            col = COL_W'($urandom);
            row = ROW_W'($urandom);
        end else begin
            col = COL_W'($urandom_range(0, cols - 1));
            row = ROW_W'(cfg_shadow.image_height - 1 - $urandom_range(0, rows - 1));
        end
        send_pixel(col, row);
    endtask

    // reset registers: corners, a point deep in the set, rows past the height
    task automatic test_reset_values();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd500, 12'd500);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd250, 12'd1000);
        send_pixel(12'd300, 12'd999);
        drain();
    endtask

    task automatic test_register_extremes();
        // every register at its top or bottom: huge exact c, escape at once
        write_config('{re_origin: 32'h8000_0000, real_step: 31'h7FFF_FFFF,
                       im_origin: 32'h7FFF_FFFF, imag_step: 31'h7FFF_FFFF,
                       image_height: 13'h1FFF, max_iter: 16'hFFFF,
                       colour_base: 24'hFF_FFFF, colour_step: 32'hFFFF_FFFF});
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        drain();
        // c at the origin runs the full 16-bit limit, colour clips
        write_config('{re_origin: 32'h0, real_step: 31'h0, im_origin: 32'h0, imag_step: 31'h0,
                       image_height: 13'd1, max_iter: 16'hFFFF,
                       colour_base: 24'h12_3456, colour_step: 32'hFFFF_FFFF});
        send_pixel(12'd4095, 12'd0);
        drain();
        // zero limit and zero height: one step, every flipped row negative
        write_config('{re_origin: 32'hE000_0000, real_step: 31'h0040_0000,
                       im_origin: 32'h0, imag_step: 31'h0040_0000,
                       image_height: 13'd0, max_iter: 16'd0,
                       colour_base: 24'hAB_CDEF, colour_step: 32'h0000_8000});
        send_pixel(12'd64, 12'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd128, 12'd4095);
        send_pixel(12'd4095, 12'd1);
        drain();
        // 1/64 grid on the real axis: c = -2, -1, -1/4, the cusp at 1/4,
        // 3/2 (escapes on the second step) and 3/2 - 3/2 i (escapes on |z|^2)
        write_config('{re_origin: 32'hE000_0000, real_step: 31'h0040_0000,
                       im_origin: 32'h0, imag_step: 31'h0040_0000,
                       image_height: 13'd1, max_iter: 16'd1000,
                       colour_base: 24'h00_0010, colour_step: 32'h0012_3456});
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd64, 12'd0);
        send_pixel(12'd112, 12'd0);
        send_pixel(12'd144, 12'd0);
        send_pixel(12'd224, 12'd0);
        send_pixel(12'd224, 12'd96);
        drain();
    endtask

    // several windows near the set; the last one with raw random registers
    task automatic test_random_windows();
        t_cfg win;
        int   cols;
        int   rows;
        for (int phase = 0; phase < 4; phase++) begin
            pick_window(win, cols, rows);
            if (phase == 3) begin
                win.re_origin    = $urandom;
                win.real_step    = 31'($urandom);
                win.im_origin    = $urandom;
                win.imag_step    = 31'($urandom);
                win.image_height = 13'($urandom);
            end
            write_config(win);
            repeat (12) send_window_pixel(cols, rows);
            drain();
        end
    endtask

    // sink holds off while short requests keep coming, so the unit backs up
    task automatic test_backpressure();
        t_cfg win;
        int   cols;
        int   rows;
        pick_window(win, cols, rows);
        win.max_iter = 16'($urandom_range(2, 12));
        write_config(win);
        sink_stall_req = LONG_STALL;
        repeat (14) send_window_pixel(cols, rows);
        drain();
    endtask

    // closing stretch at full rate on both sides
    task automatic test_no_idle();
        t_cfg win;
        int   cols;
        int   rows;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        pick_window(win, cols, rows);
        write_config(win);
        repeat (16) send_window_pixel(cols, rows);
        drain();
    endtask

    // compare one accepted result with the oldest expectation
    function automatic void check_pixel(t_pixel_out got);
        t_pixel_out want;
        if (awaited_pixels.size() == 0) begin
            $error("unexpected result: pixel_colour %06h iterations %0d",
                   got.colour, got.iterations);
            mismatch_count++;
            return;
        end
        want = awaited_pixels.pop_front();
        if (got.colour !== want.colour) begin
            $error("pixel_colour: expected %06h, actual %06h", want.colour, got.colour);
            mismatch_count++;
        end
        if (got.iterations !== want.iterations) begin
            $error("iterations: expected %0d, actual %0d", want.iterations, got.iterations);
            mismatch_count++;
        end
    endfunction

    // result side: check each handshake, then choose tready for the next cycle
    initial begin
        int gap_left;
        gap_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                check_pixel(m_axis_tdata);
            if (sink_stall_req > 0) begin
                gap_left       = sink_stall_req;
                sink_stall_req = 0;
            end else if (gap_left == 0 && sink_idle_en && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(1, 3);
            end
            if (gap_left > 0) begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        cfg_shadow     = RESET_CFG;
        mismatch_count = 0;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;
        sink_stall_req = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_register_extremes();
        test_random_windows();
        test_backpressure();
        test_no_idle();

        if (mismatch_count == 0)
            $display("mandelbrot_escape_time_pixel_unit_test: done, clean");
        else
            $display("mandelbrot_escape_time_pixel_unit_test: done, errors");
        $finish;
    end

    // watchdog, well beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("mandelbrot_escape_time_pixel_unit_test: done, errors");
        $finish;
    end

endmodule
